// ===== src/vertical_diffusion_tendency_macros.svh =====
// ----------------------------------------------------------------------------
// vertical diffusion tendency assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef VERTICAL_DIFFUSION_TENDENCY_MACROS_SVH
`define VERTICAL_DIFFUSION_TENDENCY_MACROS_SVH

// same-cycle implication
`define VDT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/vdt_pkg.sv =====
// ----------------------------------------------------------------------------
// vdt_pkg
// types, constants and helpers of the vertical diffusion tendency block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdt_pkg;

    localparam int IN_W      = 240;
    localparam int OUT_W     = 200;
    localparam int NUM_W     = 80;
    localparam int DEN_W     = 96;
    localparam int PROD_W    = 56;
    localparam int DZ_W      = 47;
    localparam int DZS_W     = 48;
    localparam int STEP_W    = 8;
    localparam int MCNT_W    = 6;

    localparam logic [STEP_W-1:0] FLUX_STEPS     = 8'd88;
    localparam logic [STEP_W-1:0] TEND_STEPS_END = 8'd144;
    localparam logic [STEP_W-1:0] TEND_STEPS_MID = 8'd145;
    localparam logic [MCNT_W-1:0] MUL_STEPS      = 6'd48;

    localparam logic [DZ_W-1:0] TINY_UNITS = 47'd4295;
    localparam logic [47:0]     POS_SAT    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0]     NEG_SAT    = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        LS_NONE,
        LS_BOTTOM,
        LS_ABOVE
    } t_levels_seen;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUX_GO,
        S_FLUX_WAIT,
        S_MUL_GO,
        S_MUL,
        S_TEND_GO,
        S_TEND_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic flux_mode;
        logic mid_shift;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    // interface spacing in 2^-32 m, floored
    function automatic logic [DZ_W-1:0] spacing(input logic [30:0] z_hi,
                                                input logic [30:0] z_lo);
        logic [30:0] d;
        d = z_hi - z_lo;
        if (z_hi > z_lo) begin
            return {d, 16'b0};
        end
        return TINY_UNITS;
    endfunction

    // density in 2^-32 units, floored
    function automatic logic [DZ_W-1:0] density(input logic [30:0] rho);
        if (rho == 31'd0) begin
            return TINY_UNITS;
        end
        return {rho, 16'b0};
    endfunction

endpackage

// ===== src/vertical_diffusion_tendency.sv =====
// ----------------------------------------------------------------------------
// vertical_diffusion_tendency
// streaming vertical diffusion tendency of a column, one level per word
// ----------------------------------------------------------------------------
// usage
//   slave channel: one word per level, bottom level first. tdata carries the
//   profiles, diffusivities, lower interface height and density; tuser flags
//   the first level of a column and tlast the top level.
//   master channel: one word per finished level: four saturated tendencies
//   and the level index in tdata, tlast on the top level's tendency.
//   the tendency of a level leaves once the level above it has arrived; the
//   top-level word yields two output words.
// sequencing
//   a first level is taken and yields nothing (a one-level column yields a zero
//   word the next cycle). any other level runs four flux divisions of 88 steps
//   on the one shared bit-serial divider, a 48-step serial multiply for the
//   denominator and four tendency divisions of 144 or 145 steps on the same
//   divider. the top level adds a further multiply and four tendency divisions
//   for its own tendency. o_s_axis_tready is high only while idle.
// reset and stall
//   synchronous active-low reset empties the window and returns to idle.
//   a stalled output word holds its data; the sequencer waits with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertical_diffusion_tendency #(
    parameter int MAX_LEVELS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // u[31:0] v[63:32] theta[95:64] qv[127:96] k_mom[150:128]
    // k_heat[173:151] z_iface[204:174] rho[235:205] zero pad[239:236]
    input  logic [vdt_pkg::IN_W-1:0]     i_s_axis_tdata,
    // first_level
    input  logic                         i_s_axis_tuser,
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // du_dt[47:0] dv_dt[95:48] dtheta_dt[143:96] dqv_dt[191:144]
    // level_index[199:192]
    output logic [vdt_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                         o_m_axis_tlast
);

    localparam int CW = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [CW:0]   MAXV    = (CW+1)'(MAX_LEVELS);
    localparam logic [CW-1:0] MAXV_M1 = CW'(MAX_LEVELS - 1);

    // state and sequencing
    vdt_pkg::t_state        r_state, n_state;
    vdt_pkg::t_levels_seen  r_seen;
    logic [CW-1:0]          r_cnt;
    logic [1:0]             r_comp;
    logic                   r_phase;     // 0: level below the new one, 1: top level
    logic                   r_commit;    // window moves when the word is taken
    logic                   r_bottom;
    logic                   r_last_in;

    // window of the current level
    logic [31:0]            r_pc [4];
    logic [30:0]            r_z1, r_z0;
    logic [30:0]            r_rho;
    logic [79:0]            r_fdn [4];   // lower-face fluxes of the current level

    // newly arrived level
    logic [31:0]            r_pn [4];
    logic [22:0]            r_km_new, r_kh_new;
    logic [30:0]            r_z_new, r_rho_new;
    logic [vdt_pkg::DZ_W-1:0] r_dzu, r_dzd;
    logic [79:0]            r_fup [4];
    logic                   r_neg;

    // serial multiplier for rho * thickness
    logic [vdt_pkg::DEN_W-1:0]  r_ma, r_acc;
    logic [vdt_pkg::DZS_W-1:0]  r_mb;
    logic [vdt_pkg::MCNT_W-1:0] r_mcnt;

    // output word
    logic [47:0]            r_res [4];
    logic [7:0]             r_idx;
    logic                   r_olast;

    // divider
    vdt_pkg::t_div_req      div_req;
    vdt_pkg::t_div_rsp      div_rsp;
    logic [79:0]            div_num, div_quot;
    logic [vdt_pkg::DEN_W-1:0] div_den;
    logic                   div_ovf;

    // unpacked input word
    logic [31:0]            in_p [4];
    logic [22:0]            in_km, in_kh;
    logic [30:0]            in_z, in_rho;
    logic                   in_first, in_last, start_col, accept;

    // per-step datapath
    logic [32:0]            dp, dp_mag;
    logic [55:0]            prod;
    logic [79:0]            tn, tn_mag;
    logic [47:0]            sat;
    logic [vdt_pkg::DZ_W-1:0]  rho32;
    logic [vdt_pkg::DZS_W-1:0] dz_den;
    logic [CW:0]            cnt_inc;
    logic [CW-1:0]          cnt_next;
    logic [CW+7:0]          idx_cur, idx_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_p[i] = i_s_axis_tdata[32*i +: 32];
        end
        in_km     = i_s_axis_tdata[150:128];
        in_kh     = i_s_axis_tdata[173:151];
        in_z      = i_s_axis_tdata[204:174];
        in_rho    = i_s_axis_tdata[235:205];
        in_first  = i_s_axis_tuser;
        in_last   = i_s_axis_tlast;
        start_col = in_first || (r_seen == vdt_pkg::LS_NONE);
        accept    = (r_state == vdt_pkg::S_IDLE) && i_s_axis_tvalid;
    end

    // level counter stops at the top index
    always_comb begin
        cnt_inc  = {1'b0, r_cnt} + 1'b1;
        cnt_next = (cnt_inc < MAXV) ? cnt_inc[CW-1:0] : MAXV_M1;
        idx_cur  = {8'b0, r_cnt};
        idx_next = {8'b0, cnt_next};
    end

    // face flux numerator: k * |dp|
    always_comb begin
        dp     = {r_pn[r_comp][31], r_pn[r_comp]} - {r_pc[r_comp][31], r_pc[r_comp]};
        dp_mag = dp[32] ? (33'd0 - dp) : dp;
        prod   = 56'(r_comp[1] ? r_kh_new : r_km_new) * 56'(dp_mag);
    end

    // tendency numerator: flux difference
    always_comb begin
        if (r_phase) begin
            tn = 80'd0 - r_fup[r_comp];
        end else if (r_bottom) begin
            tn = r_fup[r_comp];
        end else begin
            tn = r_fup[r_comp] - r_fdn[r_comp];
        end
        tn_mag = tn[79] ? (80'd0 - tn) : tn;
    end

    // denominator operands
    always_comb begin
        rho32 = r_phase ? vdt_pkg::density(r_rho_new) : vdt_pkg::density(r_rho);
        if (r_phase || r_bottom) begin
            dz_den = {1'b0, r_dzu};
        end else begin
            dz_den = {1'b0, r_dzu} + {1'b0, r_dzd};
        end
    end

    // signed 48-bit saturation of the quotient
    always_comb begin
        if (div_ovf || (|div_quot[79:47])) begin
            sat = r_neg ? vdt_pkg::NEG_SAT : vdt_pkg::POS_SAT;
        end else begin
            sat = r_neg ? (48'd0 - div_quot[47:0]) : div_quot[47:0];
        end
    end

    always_comb begin
        div_num = (r_state == vdt_pkg::S_FLUX_GO) ? {24'b0, prod} : tn_mag;
        div_den = (r_state == vdt_pkg::S_FLUX_GO) ? {49'b0, r_dzu} : r_acc;
    end

    vdt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        div_req = '0;
        case (r_state)
            vdt_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (!start_col) begin
                        n_state = vdt_pkg::S_FLUX_GO;
                    end else if (in_last) begin
                        n_state = vdt_pkg::S_OUT;
                    end
                end
            end
            vdt_pkg::S_FLUX_GO: begin
                div_req.start     = 1'b1;
                div_req.flux_mode = 1'b1;
                n_state           = vdt_pkg::S_FLUX_WAIT;
            end
            vdt_pkg::S_FLUX_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (&r_comp) ? vdt_pkg::S_MUL_GO : vdt_pkg::S_FLUX_GO;
                end
            end
            vdt_pkg::S_MUL_GO: begin
                n_state = vdt_pkg::S_MUL;
            end
            vdt_pkg::S_MUL: begin
                if (r_mcnt == 6'd1) begin
                    n_state = vdt_pkg::S_TEND_GO;
                end
            end
            vdt_pkg::S_TEND_GO: begin
                div_req.start     = 1'b1;
                div_req.mid_shift = !r_phase && !r_bottom;
                n_state           = vdt_pkg::S_TEND_WAIT;
            end
            vdt_pkg::S_TEND_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (&r_comp) ? vdt_pkg::S_OUT : vdt_pkg::S_TEND_GO;
                end
            end
            vdt_pkg::S_OUT: begin
                if (i_m_axis_tready) begin
                    if (r_commit && !r_phase && r_last_in) begin
                        n_state = vdt_pkg::S_MUL_GO;
                    end else begin
                        n_state = vdt_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = vdt_pkg::S_IDLE;
            end
        endcase
    end

    // column control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= vdt_pkg::LS_NONE;
            r_cnt    <= '0;
            r_comp   <= '0;
            r_phase  <= 1'b0;
            r_commit <= 1'b0;
        end else begin
            case (r_state)
                vdt_pkg::S_IDLE: begin
                    if (accept) begin
                        r_comp  <= '0;
                        r_phase <= 1'b0;
                        if (start_col) begin
                            r_cnt    <= '0;
                            r_commit <= 1'b0;
                            r_seen   <= in_last ? vdt_pkg::LS_NONE : vdt_pkg::LS_BOTTOM;
                        end else begin
                            r_commit <= 1'b1;
                        end
                    end
                end
                vdt_pkg::S_FLUX_WAIT, vdt_pkg::S_TEND_WAIT: begin
                    if (div_rsp.done) begin
                        r_comp <= r_comp + 1'b1;
                    end
                end
                vdt_pkg::S_OUT: begin
                    if (i_m_axis_tready && r_commit) begin
                        if (!r_phase && r_last_in) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_cnt  <= cnt_next;
                            r_seen <= r_last_in ? vdt_pkg::LS_NONE : vdt_pkg::LS_ABOVE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // window and arithmetic registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vdt_pkg::S_IDLE: begin
                if (accept) begin
                    if (start_col) begin
                        r_pc    <= in_p;
                        r_z1    <= in_z;
                        r_rho   <= in_rho;
                        r_idx   <= '0;
                        r_olast <= 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            r_res[i] <= '0;
                        end
                    end else begin
                        r_pn      <= in_p;
                        r_km_new  <= in_km;
                        r_kh_new  <= in_kh;
                        r_z_new   <= in_z;
                        r_rho_new <= in_rho;
                        r_last_in <= in_last;
                        r_bottom  <= (r_seen == vdt_pkg::LS_BOTTOM);
                        r_dzu     <= vdt_pkg::spacing(in_z, r_z1);
                        r_dzd     <= vdt_pkg::spacing(r_z1, r_z0);
                    end
                end
            end
            vdt_pkg::S_FLUX_GO: begin
                r_neg <= dp[32];
            end
            vdt_pkg::S_FLUX_WAIT: begin
                if (div_rsp.done) begin
                    r_fup[r_comp] <= r_neg ? (80'd0 - div_quot) : div_quot;
                end
            end
            vdt_pkg::S_MUL_GO: begin
                r_ma   <= {49'b0, rho32};
                r_mb   <= dz_den;
                r_acc  <= '0;
                r_mcnt <= vdt_pkg::MUL_STEPS;
            end
            vdt_pkg::S_MUL: begin
                r_acc  <= r_acc + (r_mb[0] ? r_ma : '0);
                r_ma   <= {r_ma[vdt_pkg::DEN_W-2:0], 1'b0};
                r_mb   <= {1'b0, r_mb[vdt_pkg::DZS_W-1:1]};
                r_mcnt <= r_mcnt - 1'b1;
            end
            vdt_pkg::S_TEND_GO: begin
                r_neg <= tn[79];
            end
            vdt_pkg::S_TEND_WAIT: begin
                if (div_rsp.done) begin
                    r_res[r_comp] <= sat;
                    r_idx         <= r_phase ? idx_next[7:0] : idx_cur[7:0];
                    r_olast       <= r_phase;
                end
            end
            vdt_pkg::S_OUT: begin
                if (i_m_axis_tready && r_commit && !(!r_phase && r_last_in)) begin
                    r_pc  <= r_pn;
                    r_z0  <= r_z1;
                    r_z1  <= r_z_new;
                    r_rho <= r_rho_new;
                    r_fdn <= r_fup;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == vdt_pkg::S_IDLE);
    assign o_m_axis_tvalid = (r_state == vdt_pkg::S_OUT);
    assign o_m_axis_tdata  = {r_idx, r_res[3], r_res[2], r_res[1], r_res[0]};
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== src/vdt_divider.sv =====
// ----------------------------------------------------------------------------
// vdt_divider
// restoring bit-serial divider, floor(num * 2^sh / den), one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdt_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vdt_pkg::t_div_req             i_req,
    input  logic [vdt_pkg::NUM_W-1:0]     i_num,
    input  logic [vdt_pkg::DEN_W-1:0]     i_den,
    output vdt_pkg::t_div_rsp             o_rsp,
    output logic [vdt_pkg::NUM_W-1:0]     o_quot,
    output logic                          o_ovf
);

    logic                          r_busy;
    logic                          r_done;
    logic [vdt_pkg::STEP_W-1:0]    r_cnt;
    logic [vdt_pkg::NUM_W-1:0]     r_num;
    logic [vdt_pkg::DEN_W-1:0]     r_den;
    logic [vdt_pkg::DEN_W-1:0]     r_rem;
    logic [vdt_pkg::NUM_W-1:0]     r_q;
    logic                          r_ovf;

    logic [vdt_pkg::DEN_W:0]       rem_sh;
    logic [vdt_pkg::DEN_W+1:0]     diff;
    logic [vdt_pkg::DEN_W-1:0]     n_rem;
    logic [vdt_pkg::STEP_W-1:0]    n_steps;

    always_comb begin
        rem_sh = {r_rem, r_num[vdt_pkg::NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b0, r_den};
        n_rem  = diff[vdt_pkg::DEN_W+1] ? rem_sh[vdt_pkg::DEN_W-1:0]
                                        : diff[vdt_pkg::DEN_W-1:0];
        if (i_req.flux_mode) begin
            n_steps = vdt_pkg::FLUX_STEPS;
        end else if (i_req.mid_shift) begin
            n_steps = vdt_pkg::TEND_STEPS_MID;
        end else begin
            n_steps = vdt_pkg::TEND_STEPS_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= n_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.flux_mode ? {i_num[vdt_pkg::PROD_W-1:0], 24'b0} : i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[vdt_pkg::NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= {r_q[vdt_pkg::NUM_W-2:0], ~diff[vdt_pkg::DEN_W+1]};
            r_ovf <= r_ovf | r_q[vdt_pkg::NUM_W-1];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_q;
    assign o_ovf      = r_ovf;

endmodule

// ===== src/vdt_checker.sv =====
// ----------------------------------------------------------------------------
// vdt_checker
// port-level checks of the vertical diffusion tendency block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertical_diffusion_tendency_macros.svh"

module vdt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [vdt_pkg::OUT_W-1:0]    o_m_axis_tdata
);

    logic stall;

    assign stall = o_m_axis_tvalid && !i_m_axis_tready;

    `VDT_ASSERT_NXT(a_out_hold, stall, o_m_axis_tvalid, "output word dropped while stalled")
    `VDT_ASSERT_NXT(a_out_stable, stall, $stable(o_m_axis_tdata), "output word changed on stall")
    `VDT_ASSERT_IMP(a_no_overlap, o_m_axis_tvalid, !o_s_axis_tready, "input taken while a result waits")
    `VDT_ASSERT_NXT(a_ready_hold, o_s_axis_tready && !i_s_axis_tvalid, o_s_axis_tready, "ready lost while idle")
    `VDT_ASSERT_NXT(a_gap_after_out, o_m_axis_tvalid && i_m_axis_tready, !o_m_axis_tvalid, "back-to-back output words")

endmodule

bind vertical_diffusion_tendency vdt_checker u_vdt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertical diffusion tendency block: streams
// column levels with random gaps and output stalls, predicts every tendency
// word with wide exact integer arithmetic and compares each output field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int WD_LIMIT  = 20000;
    localparam int LONG_HOLD = 3000;
    localparam int MAXLEV    = 256;
    localparam int KIND_BOT  = 0;
    localparam int KIND_MID  = 1;
    localparam int KIND_TOP  = 2;

    typedef struct packed {
        logic [30:0] rho;
        logic [30:0] z;
        logic [22:0] kh;
        logic [22:0] km;
        logic [31:0] qv;
        logic [31:0] th;
        logic [31:0] v;
        logic [31:0] u;
    } t_level;

    typedef struct {
        logic [47:0] tend [4];
        logic [7:0]  idx;
        logic        last;
    } t_tend_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [vdt_pkg::IN_W-1:0]   i_s_axis_tdata;
    logic                       i_s_axis_tuser;
    logic                       i_s_axis_tlast;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic [vdt_pkg::OUT_W-1:0]  o_m_axis_tdata;
    logic                       o_m_axis_tlast;

    // column window held by the predictor
    logic signed [31:0] prof_lo [4];
    logic signed [31:0] prof_cur [4];
    logic [30:0]        z_lo, z_cur;
    logic [22:0]        km_cur, kh_cur;
    logic [30:0]        rho_cur;
    int                 seen;
    int                 lev_cnt;

    t_tend_word         tend_q [$];
    int                 errors;
    int                 quiet_cnt;
    bit                 calm;
    int                 hold_cycles;
    int                 hold_req;
    int                 hold_ack;

    vertical_diffusion_tendency u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // spacing in 2^-32 m, floored at 1e-6
    function automatic logic [255:0] gap_units(logic [30:0] hi, logic [30:0] lo);
        if (hi > lo) return 256'(hi - lo) << 16;
        return 256'd4295;
    endfunction

    function automatic logic [255:0] rho_units(logic [30:0] r);
        if (r == 0) return 256'd4295;
        return 256'(r) << 16;
    endfunction

    function automatic string tend_name(int i);
        case (i)
            0: return "du_dt";
            1: return "dv_dt";
            2: return "dtheta_dt";
            default: return "dqv_dt";
        endcase
    endfunction

    function automatic logic signed [255:0] face_flux(logic [22:0] k,
                                                      logic signed [32:0] dp,
                                                      logic [255:0] dz);
        logic [255:0] mag;
        logic [255:0] f;
        mag = dp < 0 ? 256'(-dp) : 256'(dp);
        f = ((256'(k) * mag) << 32) / dz;
        return dp < 0 ? -$signed(f) : $signed(f);
    endfunction

    function automatic logic [47:0] level_tendency(int kind, logic signed [31:0] pdn,
            logic signed [31:0] pc, logic signed [31:0] pup, logic [22:0] kdn,
            logic [22:0] kup, logic [255:0] dzd, logic [255:0] dzu,
            logic [255:0] r32);
        logic signed [255:0] n;
        logic [255:0]        den, mag, q;
        int                  sh;
        n = 0;
        sh = 64;
        if (kind != KIND_TOP) n = n + face_flux(kup, 33'(pup) - 33'(pc), dzu);
        if (kind != KIND_BOT) n = n - face_flux(kdn, 33'(pc) - 33'(pdn), dzd);
        if (kind == KIND_BOT) den = r32 * dzu;
        else if (kind == KIND_TOP) den = r32 * dzd;
        else begin
            den = r32 * (dzu + dzd);
            sh = 65;
        end
        mag = n < 0 ? -n : n;
        q = (mag << sh) / den;
        if (q > 256'(vdt_pkg::POS_SAT)) return n < 0 ? vdt_pkg::NEG_SAT : vdt_pkg::POS_SAT;
        return n < 0 ? 48'(-q) : q[47:0];
    endfunction

    // advance the column window by one accepted level, queue its results
    task automatic predict_level(t_level lv, logic first, logic last);
        logic signed [31:0] p [4];
        logic [255:0]       dzu, dzd, r32;
        t_tend_word         w;
        int                 nxt;
        p = '{lv.u, lv.v, lv.th, lv.qv};
        if (first || seen == 0) begin
            prof_cur = p;
            z_cur = lv.z;
            km_cur = lv.km;
            kh_cur = lv.kh;
            rho_cur = lv.rho;
            lev_cnt = 0;
            if (last) begin
                seen = 0;
                foreach (w.tend[i]) w.tend[i] = '0;
                w.idx = '0;
                w.last = 1'b1;
                tend_q.push_back(w);
            end else begin
                seen = 1;
            end
            return;
        end
        dzu = gap_units(lv.z, z_cur);
        dzd = gap_units(z_cur, z_lo);
        r32 = rho_units(rho_cur);
        for (int i = 0; i < 4; i++)
            w.tend[i] = level_tendency(seen == 1 ? KIND_BOT : KIND_MID, prof_lo[i],
                prof_cur[i], p[i], i < 2 ? km_cur : kh_cur, i < 2 ? lv.km : lv.kh,
                dzd, dzu, r32);
        w.idx = 8'(lev_cnt);
        w.last = 1'b0;
        tend_q.push_back(w);
        nxt = lev_cnt + 1 < MAXLEV ? lev_cnt + 1 : MAXLEV - 1;
        if (last) begin
            for (int i = 0; i < 4; i++)
                w.tend[i] = level_tendency(KIND_TOP, prof_cur[i], p[i], 0,
                    i < 2 ? lv.km : lv.kh, 0, dzu, dzu, rho_units(lv.rho));
            w.idx = 8'(nxt);
            w.last = 1'b1;
            tend_q.push_back(w);
        end
        prof_lo = prof_cur;
        prof_cur = p;
        z_lo = z_cur;
        z_cur = lv.z;
        km_cur = lv.km;
        kh_cur = lv.kh;
        rho_cur = lv.rho;
        lev_cnt = nxt;
        seen = last ? 0 : 2;
    endtask

    // offer one level word and wait for it to be taken
    task automatic send_level(t_level lv, logic first, logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, lv};
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_level(lv, first, last);
    endtask

    // stop offering after the last word of a burst
    task automatic stop_input();
        i_s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_profile();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_level rand_level(logic [30:0] z_below);
        t_level lv;
        lv.u  = rand_profile();
        lv.v  = rand_profile();
        lv.th = rand_profile();
        lv.qv = rand_profile();
        lv.km = $urandom_range(0, 9) == 0 ? 23'($urandom)
                                          : 23'($urandom_range(0, 6553600));
        lv.kh = $urandom_range(0, 9) == 0 ? 23'($urandom)
                                          : 23'($urandom_range(0, 6553600));
        case ($urandom_range(0, 9))
            0: lv.z = z_below;
            1: lv.z = 31'($urandom);
            default: lv.z = 31'(z_below + $urandom_range(1, 1 << 22));
        endcase
        case ($urandom_range(0, 7))
            0: lv.rho = '0;
            1: lv.rho = 31'($urandom);
            default: lv.rho = 31'($urandom_range(1, 1 << 18));
        endcase
        return lv;
    endfunction

    task automatic send_column(int n);
        t_level      lv;
        logic [30:0] z;
        z = 31'($urandom_range(0, 1 << 20));
        for (int i = 0; i < n; i++) begin
            lv = rand_level(z);
            z = lv.z;
            send_level(lv, i == 0, i == n - 1);
        end
    endtask

    task automatic test_directed();
        t_level lv;
        // level with no column open, then a one-level column
        lv = rand_level(31'd100);
        send_level(lv, 1'b0, 1'b0);
        send_level(rand_level(31'd0), 1'b1, 1'b1);
        // field extremes: extreme profiles, max k, zero heights and density
        lv = '{rho: '0, z: '0, kh: '1, km: '1, qv: 32'h7FFF_FFFF,
               th: 32'h8000_0000, v: 32'h7FFF_FFFF, u: 32'h8000_0000};
        send_level(lv, 1'b1, 1'b0);
        lv = '{rho: '1, z: '1, kh: '0, km: '0, qv: 32'h8000_0000,
               th: 32'h7FFF_FFFF, v: 32'h8000_0000, u: 32'h7FFF_FFFF};
        send_level(lv, 1'b0, 1'b0);
        lv.kh = '1;
        lv.km = '1;
        send_level(lv, 1'b0, 1'b1);
        // restart inside an open column drops it
        send_column(1);
        send_level(rand_level(31'd10), 1'b1, 1'b0);
        send_level(rand_level(31'd10), 1'b0, 1'b0);
        send_column(3);
        send_column(2);
    endtask

    task automatic test_random_columns(int n_items);
        int sent, n;
        sent = 0;
        while (sent < n_items) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            if ($urandom_range(0, 19) == 0) begin
                // column left open, then restarted
                send_level(rand_level(31'd0), 1'b1, 1'b0);
                sent++;
            end
            send_column(n);
            sent += n;
        end
    endtask

    // output held off long enough that the block stops taking input
    task automatic test_output_stall();
        hold_req++;
        send_column(4);
        stop_input();
        wait (tend_q.size() == 0);
        send_column(3);
    endtask

    // level counter saturation on a tall column
    task automatic test_tall_column();
        send_column(MAXLEV + 4);
    endtask

    // output side ready pattern, with an optional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (hold_ack != hold_req) begin
            i_m_axis_tready <= 1'b0;
            hold_ack <= hold_req;
            hold_cycles <= LONG_HOLD;
        end else if (hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!calm && $urandom_range(0, 40) == 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= $urandom_range(0, 7);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // compare each tendency word with the oldest prediction
    always @(posedge i_clk) begin
        t_tend_word w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (tend_q.size() == 0) begin
                $error("unexpected tendency word %h", o_m_axis_tdata);
                errors++;
            end else begin
                w = tend_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (o_m_axis_tdata[48*i +: 48] !== w.tend[i]) begin
                        $error("%s: expected %h got %h", tend_name(i), w.tend[i],
                               o_m_axis_tdata[48*i +: 48]);
                        errors++;
                    end
                if (o_m_axis_tdata[199:192] !== w.idx) begin
                    $error("level_index: expected %0d got %0d", w.idx,
                           o_m_axis_tdata[199:192]);
                    errors++;
                end
                if (o_m_axis_tlast !== w.last) begin
                    $error("last_result: expected %0b got %0b", w.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt > WD_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b1;
        errors = 0;
        quiet_cnt = 0;
        calm = 1'b0;
        hold_cycles = 0;
        hold_req = 0;
        hold_ack = 0;
        seen = 0;
        lev_cnt = 0;
        z_lo = '0;
        z_cur = '0;
        km_cur = '0;
        kh_cur = '0;
        rho_cur = '0;
        foreach (prof_lo[i]) begin
            prof_lo[i] = '0;
            prof_cur[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_stall();
        test_random_columns(300);
        stop_input();
        wait (tend_q.size() == 0);
        test_tall_column();
        test_random_columns(250);
        calm = 1'b1;
        test_random_columns(100);

        stop_input();
        wait (tend_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== vertical_diffusion_tendency.f =====
+incdir+src
src/vdt_pkg.sv
src/vdt_divider.sv
src/vertical_diffusion_tendency.sv
src/vdt_checker.sv
tb/tb_top.sv
